>>> hdl/ihp_pkg.sv
package ihp_pkg;

	// longest capture that is parsed, bytes beyond it are ignored
	localparam int unsigned MAX_CAPTURE = 65535;

	// parser phases
	typedef enum logic [8:0] {
		PH_VER      = 9'b000000001,
		PH_V4       = 9'b000000010,
		PH_V6       = 9'b000000100,
		PH_EXT_NXT  = 9'b000001000,
		PH_EXT_LEN  = 9'b000010000,
		PH_EXT_SKIP = 9'b000100000,
		PH_FRAG     = 9'b001000000,
		PH_DONE     = 9'b010000000,
		PH_DRAIN    = 9'b100000000
	} phase_t;

	// result status codes
	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_TRUNCATED = 3'd1;
	localparam logic [2:0] ST_MALFORMED = 3'd2;
	localparam logic [2:0] ST_UNKNOWN   = 3'd3;
	localparam logic [2:0] ST_FRAGMENT  = 3'd4;

	// ip versions
	localparam logic [3:0] VER_IPV4 = 4'd4;
	localparam logic [3:0] VER_IPV6 = 4'd6;

	// ipv6 next header codes
	localparam logic [7:0] NH_HOP_BY_HOP = 8'd0;
	localparam logic [7:0] NH_ROUTING    = 8'd43;
	localparam logic [7:0] NH_FRAGMENT   = 8'd44;
	localparam logic [7:0] NH_AUTH       = 8'd51;
	localparam logic [7:0] NH_DEST_OPTS  = 8'd60;

	// fixed ipv6 header length
	localparam logic [16:0] IPV6_HDR_LEN = 17'd40;

	// prefix of a v4-mapped address in the low 64 bits
	localparam logic [31:0] V4_MAP_PREFIX = 32'h0000ffff;

endpackage

>>> hdl/ip_header_parser.sv
// a final byte passes through the byte register, and its result is then loaded into the result register
// throughput: one packet byte per cycle; a final byte waits only while a result is held
// the byte register and the result register decouple the two channels
// reset (arst_n low, asynchronous) empties both registers and returns the parser to the
// version byte of a new packet
module ip_header_parser #(
	parameter int unsigned MAX_CAPTURE = ihp_pkg::MAX_CAPTURE
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  packet_byte,
	input  logic        last_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  status,
	output logic [3:0]  ip_version,
	output logic [7:0]  protocol,
	output logic [7:0]  ttl_value,
	output logic [63:0] source_high,
	output logic [63:0] source_low,
	output logic [63:0] dest_high,
	output logic [63:0] dest_low,
	output logic [15:0] payload_length,
	output logic [16:0] flow_bytes,
	output logic        dont_fragment,
	output logic        is_fragment
);

	localparam logic [16:0] MaxCap = 17'(MAX_CAPTURE);

	// input register
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;
	logic       advance;
	logic       in_xfer;

	// parser state
	ihp_pkg::phase_t phase_q, n_phase, nh_phase;
	logic [15:0] count_q, n_count;
	logic [3:0]  hw_q, n_hw;
	logic [15:0] tl_q, n_tl;
	logic [15:0] rem_q, n_rem;
	logic [15:0] ext_q, n_ext;
	logic [7:0]  nxt_q, n_nxt;
	logic [15:0] frag_q, n_frag;
	logic [7:0]  hop_q, n_hop;
	logic [63:0] src_hi_q, n_src_hi;
	logic [63:0] src_lo_q, n_src_lo;
	logic [63:0] dst_hi_q, n_dst_hi;
	logic [63:0] dst_lo_q, n_dst_lo;
	logic [2:0]  err_q, n_err;
	logic [3:0]  ver_q, n_ver;

	// step helpers
	logic        take;
	logic [15:0] idx;
	logic [11:0] skip;
	logic [16:0] ext_end;
	logic [15:0] cap;
	logic [5:0]  size;

	// result terms
	logic [2:0]  r_status;
	logic [7:0]  r_protocol;
	logic [7:0]  r_ttl;
	logic [63:0] r_src_hi, r_src_lo, r_dst_hi, r_dst_lo;
	logic [15:0] r_plen;
	logic [16:0] r_flow;
	logic        r_df;
	logic        r_frag;
	logic        load;

	// output register
	logic        out_valid_q;

	// handshake: non-final bytes always move on, a final byte needs the result slot
	assign advance  = valid_s1 && (!last_s1 || !out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;
	assign in_xfer  = in_valid && in_ready;
	assign load     = advance && last_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_xfer || (valid_s1 && !advance);
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			byte_s1 <= packet_byte;
			last_s1 <= last_byte;
		end
	end

	// phase that follows a complete ipv6 header or extension header
	always_comb begin
		if (nxt_q == ihp_pkg::NH_HOP_BY_HOP || nxt_q == ihp_pkg::NH_ROUTING ||
		    nxt_q == ihp_pkg::NH_DEST_OPTS || nxt_q == ihp_pkg::NH_AUTH) begin
			nh_phase = ihp_pkg::PH_EXT_NXT;
		end else if (nxt_q == ihp_pkg::NH_FRAGMENT) begin
			nh_phase = ihp_pkg::PH_FRAG;
		end else begin
			nh_phase = ihp_pkg::PH_DONE;
		end
	end

	assign take    = 17'(count_q) < MaxCap;
	assign idx     = count_q;
	assign skip    = {({1'b0, byte_s1} + 9'd1), 3'b000};
	assign ext_end = 17'(ext_q) + 17'(skip);

	// per-byte field updates
	always_comb begin
		n_phase  = phase_q;
		n_count  = count_q;
		n_hw     = hw_q;
		n_tl     = tl_q;
		n_rem    = rem_q;
		n_ext    = ext_q;
		n_nxt    = nxt_q;
		n_frag   = frag_q;
		n_hop    = hop_q;
		n_src_hi = src_hi_q;
		n_src_lo = src_lo_q;
		n_dst_hi = dst_hi_q;
		n_dst_lo = dst_lo_q;
		n_err    = err_q;
		n_ver    = ver_q;
		if (take) begin
			n_count = count_q + 16'd1;
			case (phase_q)
				ihp_pkg::PH_VER: begin
					n_ver = byte_s1[7:4];
					n_hw  = byte_s1[3:0];
					if (byte_s1[7:4] == ihp_pkg::VER_IPV4) begin
						n_phase = ihp_pkg::PH_V4;
					end else if (byte_s1[7:4] == ihp_pkg::VER_IPV6) begin
						n_phase = ihp_pkg::PH_V6;
					end else begin
						n_err   = ihp_pkg::ST_UNKNOWN;
						n_phase = ihp_pkg::PH_DRAIN;
					end
				end
				ihp_pkg::PH_V4: begin
					if (idx inside {16'd2, 16'd3}) begin
						n_tl = {tl_q[7:0], byte_s1};
					end else if (idx inside {16'd6, 16'd7}) begin
						n_frag = {frag_q[7:0], byte_s1};
					end else if (idx == 16'd8) begin
						n_hop = byte_s1;
					end else if (idx == 16'd9) begin
						n_nxt = byte_s1;
					end else if (idx inside {[16'd12:16'd15]}) begin
						n_src_lo = {src_lo_q[55:0], byte_s1};
					end else if (idx inside {[16'd16:16'd19]}) begin
						n_dst_lo = {dst_lo_q[55:0], byte_s1};
					end
					if (idx == 16'd19) begin
						if (hw_q < 4'd5) begin
							n_err   = ihp_pkg::ST_MALFORMED;
							n_phase = ihp_pkg::PH_DRAIN;
						end else begin
							n_phase = ihp_pkg::PH_DONE;
						end
					end
				end
				ihp_pkg::PH_V6: begin
					if (idx inside {16'd4, 16'd5}) begin
						n_rem = {rem_q[7:0], byte_s1};
					end else if (idx == 16'd6) begin
						n_nxt = byte_s1;
					end else if (idx == 16'd7) begin
						n_hop = byte_s1;
					end else if (idx inside {[16'd8:16'd15]}) begin
						n_src_hi = {src_hi_q[55:0], byte_s1};
					end else if (idx inside {[16'd16:16'd23]}) begin
						n_src_lo = {src_lo_q[55:0], byte_s1};
					end else if (idx inside {[16'd24:16'd31]}) begin
						n_dst_hi = {dst_hi_q[55:0], byte_s1};
					end else if (idx inside {[16'd32:16'd39]}) begin
						n_dst_lo = {dst_lo_q[55:0], byte_s1};
					end
					if (idx == 16'd39) begin
						n_ext   = 16'(ihp_pkg::IPV6_HDR_LEN);
						n_phase = nh_phase;
					end
				end
				ihp_pkg::PH_EXT_NXT: begin
					n_nxt   = byte_s1;
					n_phase = ihp_pkg::PH_EXT_LEN;
				end
				ihp_pkg::PH_EXT_LEN: begin
					if (16'(skip) > rem_q) begin
						n_err   = ihp_pkg::ST_MALFORMED;
						n_phase = ihp_pkg::PH_DRAIN;
					end else if (ext_end > MaxCap) begin
						n_err   = ihp_pkg::ST_TRUNCATED;
						n_phase = ihp_pkg::PH_DRAIN;
					end else begin
						n_rem   = rem_q - 16'(skip);
						n_ext   = ext_end[15:0];
						n_phase = ihp_pkg::PH_EXT_SKIP;
					end
				end
				ihp_pkg::PH_EXT_SKIP: begin
					if (17'(idx) + 17'd1 == 17'(ext_q)) begin
						n_phase = nh_phase;
					end
				end
				ihp_pkg::PH_FRAG: begin
					if (idx == ext_q) begin
						n_nxt = byte_s1;
					end
					if (17'(idx) == 17'(ext_q) + 17'd7) begin
						n_err   = ihp_pkg::ST_FRAGMENT;
						n_phase = ihp_pkg::PH_DRAIN;
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign cap  = n_count;
	assign size = {n_hw, 2'b00};

	// result status from the state after the final byte
	always_comb begin
		case (n_phase)
			ihp_pkg::PH_DRAIN: begin
				r_status = n_err;
			end
			ihp_pkg::PH_DONE: begin
				if (n_ver == ihp_pkg::VER_IPV4) begin
					if (cap < 16'(size)) begin
						r_status = ihp_pkg::ST_TRUNCATED;
					end else if (n_frag[13:0] != 14'd0) begin
						r_status = ihp_pkg::ST_FRAGMENT;
					end else if (n_tl < 16'(size) || n_tl > cap) begin
						r_status = ihp_pkg::ST_TRUNCATED;
					end else begin
						r_status = ihp_pkg::ST_OK;
					end
				end else if (17'(n_ext) + 17'(n_rem) > 17'(cap)) begin
					r_status = ihp_pkg::ST_TRUNCATED;
				end else begin
					r_status = ihp_pkg::ST_OK;
				end
			end
			ihp_pkg::PH_FRAG: begin
				r_status = ihp_pkg::ST_MALFORMED;
			end
			default: begin
				r_status = ihp_pkg::ST_TRUNCATED;
			end
		endcase
	end

	// result fields, cleared on error status
	always_comb begin
		r_protocol = 8'd0;
		r_ttl      = 8'd0;
		r_src_hi   = 64'd0;
		r_src_lo   = 64'd0;
		r_dst_hi   = 64'd0;
		r_dst_lo   = 64'd0;
		r_plen     = 16'd0;
		r_flow     = 17'd0;
		r_df       = 1'b0;
		r_frag     = 1'b0;
		if (r_status == ihp_pkg::ST_OK || r_status == ihp_pkg::ST_FRAGMENT) begin
			r_protocol = n_nxt;
			r_ttl      = n_hop;
			r_frag     = (r_status == ihp_pkg::ST_FRAGMENT);
			if (n_ver == ihp_pkg::VER_IPV4) begin
				r_src_lo = {ihp_pkg::V4_MAP_PREFIX, n_src_lo[31:0]};
				r_dst_lo = {ihp_pkg::V4_MAP_PREFIX, n_dst_lo[31:0]};
				r_plen   = (n_tl >= 16'(size)) ? n_tl - 16'(size) : 16'd0;
				r_flow   = 17'(r_plen) + 17'(size);
				r_df     = n_frag[14];
			end else begin
				r_src_hi = n_src_hi;
				r_src_lo = n_src_lo;
				r_dst_hi = n_dst_hi;
				r_dst_lo = n_dst_lo;
				r_plen   = n_rem;
				r_flow   = 17'(n_rem) + ihp_pkg::IPV6_HDR_LEN;
			end
		end
	end

	// parser state registers, back to reset after each final byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= ihp_pkg::PH_VER;
			count_q  <= 16'd0;
			hw_q     <= 4'd0;
			tl_q     <= 16'd0;
			rem_q    <= 16'd0;
			ext_q    <= 16'd0;
			nxt_q    <= 8'd0;
			frag_q   <= 16'd0;
			hop_q    <= 8'd0;
			src_hi_q <= 64'd0;
			src_lo_q <= 64'd0;
			dst_hi_q <= 64'd0;
			dst_lo_q <= 64'd0;
			err_q    <= 3'd0;
			ver_q    <= 4'd0;
		end else if (advance) begin
			if (last_s1) begin
				phase_q  <= ihp_pkg::PH_VER;
				count_q  <= 16'd0;
				hw_q     <= 4'd0;
				tl_q     <= 16'd0;
				rem_q    <= 16'd0;
				ext_q    <= 16'd0;
				nxt_q    <= 8'd0;
				frag_q   <= 16'd0;
				hop_q    <= 8'd0;
				src_hi_q <= 64'd0;
				src_lo_q <= 64'd0;
				dst_hi_q <= 64'd0;
				dst_lo_q <= 64'd0;
				err_q    <= 3'd0;
				ver_q    <= 4'd0;
			end else begin
				phase_q  <= n_phase;
				count_q  <= n_count;
				hw_q     <= n_hw;
				tl_q     <= n_tl;
				rem_q    <= n_rem;
				ext_q    <= n_ext;
				nxt_q    <= n_nxt;
				frag_q   <= n_frag;
				hop_q    <= n_hop;
				src_hi_q <= n_src_hi;
				src_lo_q <= n_src_lo;
				dst_hi_q <= n_dst_hi;
				dst_lo_q <= n_dst_lo;
				err_q    <= n_err;
				ver_q    <= n_ver;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= load || (out_valid_q && !out_ready);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			status         <= r_status;
			ip_version     <= n_ver;
			protocol       <= r_protocol;
			ttl_value      <= r_ttl;
			source_high    <= r_src_hi;
			source_low     <= r_src_lo;
			dest_high      <= r_dst_hi;
			dest_low       <= r_dst_lo;
			payload_length <= r_plen;
			flow_bytes     <= r_flow;
			dont_fragment  <= r_df;
			is_fragment    <= r_frag;
		end
	end

	assign out_valid = out_valid_q;

endmodule

>>> tb/ip_header_parser_test.sv
`timescale 1ns / 100ps

module ip_header_parser_test;
	import ihp_pkg::*;

	// transport protocols used as the final next-header
	localparam logic [7:0] PROTO_TCP    = 8'd6;
	localparam logic [7:0] PROTO_UDP    = 8'd17;
	localparam logic [7:0] PROTO_ICMPV6 = 8'd58;

	// ipv4 flags and fragment offset word
	localparam logic [15:0] FLAG_RSVD   = 16'h8000;
	localparam logic [15:0] FLAG_DF     = 16'h4000;
	localparam logic [15:0] FLAG_MF     = 16'h2000;
	localparam logic [15:0] OFFSET_MASK = 16'h1fff;

	// one parsed header as seen on the result channel
	typedef struct packed {
		logic [2:0]  status;
		logic [3:0]  ip_ver;
		logic [7:0]  protocol;
		logic [7:0]  ttl;
		logic [63:0] src_hi;
		logic [63:0] src_lo;
		logic [63:0] dst_hi;
		logic [63:0] dst_lo;
		logic [15:0] plen;
		logic [16:0] flow;
		logic        df;
		logic        frag;
	} hdr_result_t;

	// header parse prediction and result comparison
	class header_tracker;
		hdr_result_t predicted_headers[$];
		int unsigned mismatches;
		int unsigned results_seen;

		logic [15:0] byte_cnt;
		phase_t      phase;
		logic [3:0]  ver;
		logic [3:0]  ihl;
		logic [15:0] tot_len;
		logic [15:0] rem_len;
		int unsigned ext_end;
		logic [7:0]  nxt_proto;
		logic [15:0] frag_word;
		logic [7:0]  hop;
		logic [63:0] addr[4];
		logic [2:0]  latched;

		function new();
			mismatches = 0;
			results_seen = 0;
			clear();
		endfunction

		function void clear();
			byte_cnt = '0;
			phase = PH_VER;
			ver = '0;
			ihl = '0;
			tot_len = '0;
			rem_len = '0;
			ext_end = 0;
			nxt_proto = '0;
			frag_word = '0;
			hop = '0;
			for (int i = 0; i < 4; i++)
				addr[i] = '0;
			latched = ST_OK;
		endfunction

		function void latch_status(logic [2:0] st);
			latched = st;
			phase = PH_DRAIN;
		endfunction

		// dispatch on the next header code
		function void pick_next_phase();
			if (nxt_proto == NH_HOP_BY_HOP || nxt_proto == NH_ROUTING ||
					nxt_proto == NH_DEST_OPTS || nxt_proto == NH_AUTH)
				phase = PH_EXT_NXT;
			else if (nxt_proto == NH_FRAGMENT)
				phase = PH_FRAG;
			else
				phase = PH_DONE;
		endfunction

		// final status and fields at the last byte
		function hdr_result_t summarize();
			hdr_result_t r;
			int unsigned cap;
			int unsigned size;
			int unsigned plen;
			logic [2:0] st;
			cap = byte_cnt;
			size = 32'(ihl) << 2;
			if (phase == PH_DRAIN)
				st = latched;
			else if (phase == PH_DONE && ver == VER_IPV4) begin
				if (cap < size)
					st = ST_TRUNCATED;
				else if ((frag_word & (FLAG_MF | OFFSET_MASK)) != 16'h0)
					st = ST_FRAGMENT;
				else if (tot_len < size || tot_len > cap)
					st = ST_TRUNCATED;
				else
					st = ST_OK;
			end else if (phase == PH_DONE)
				st = (ext_end + rem_len > cap) ? ST_TRUNCATED : ST_OK;
			else if (phase == PH_FRAG)
				st = ST_MALFORMED;
			else
				st = ST_TRUNCATED;

			r = '0;
			r.status = st;
			r.ip_ver = ver;
			if (st == ST_OK || st == ST_FRAGMENT) begin
				r.protocol = nxt_proto;
				r.ttl = hop;
				if (ver == VER_IPV4) begin
					r.src_lo = {V4_MAP_PREFIX, addr[1][31:0]};
					r.dst_lo = {V4_MAP_PREFIX, addr[3][31:0]};
					plen = (tot_len >= size) ? tot_len - size : 0;
					r.flow = 17'(plen + size);
					r.df = frag_word[14];
				end else begin
					r.src_hi = addr[0];
					r.src_lo = addr[1];
					r.dst_hi = addr[2];
					r.dst_lo = addr[3];
					plen = rem_len;
					r.flow = 17'(plen) + IPV6_HDR_LEN;
				end
				r.plen = 16'(plen);
				r.frag = (st == ST_FRAGMENT);
			end
			return r;
		endfunction

		// advance the parse on one accepted byte transfer
		function void parse_byte(logic [7:0] b, logic is_last);
			int unsigned idx;
			int unsigned skip;
			int unsigned stop;
			int unsigned k;
			idx = byte_cnt;
			if (idx < MAX_CAPTURE) begin
				case (phase)
				PH_VER: begin
					ver = b[7:4];
					ihl = b[3:0];
					if (ver == VER_IPV4)
						phase = PH_V4;
					else if (ver == VER_IPV6)
						phase = PH_V6;
					else
						latch_status(ST_UNKNOWN);
				end
				PH_V4: begin
					if (idx == 2 || idx == 3)
						tot_len = {tot_len[7:0], b};
					else if (idx == 6 || idx == 7)
						frag_word = {frag_word[7:0], b};
					else if (idx == 8)
						hop = b;
					else if (idx == 9)
						nxt_proto = b;
					else if (idx >= 12 && idx <= 15)
						addr[1] = {addr[1][55:0], b};
					else if (idx >= 16 && idx <= 19)
						addr[3] = {addr[3][55:0], b};
					if (idx == 19) begin
						if (ihl < 4'd5)
							latch_status(ST_MALFORMED);
						else
							phase = PH_DONE;
					end
				end
				PH_V6: begin
					if (idx == 4 || idx == 5)
						rem_len = {rem_len[7:0], b};
					else if (idx == 6)
						nxt_proto = b;
					else if (idx == 7)
						hop = b;
					else if (idx >= 8 && idx <= 39) begin
						k = ((idx - 8) >> 3) & 3;
						addr[k] = {addr[k][55:0], b};
					end
					if (idx == 39) begin
						ext_end = 40;
						pick_next_phase();
					end
				end
				PH_EXT_NXT: begin
					nxt_proto = b;
					phase = PH_EXT_LEN;
				end
				PH_EXT_LEN: begin
					skip = (b + 32'd1) << 3;
					stop = ext_end + skip;
					if (skip > rem_len)
						latch_status(ST_MALFORMED);
					else if (stop > MAX_CAPTURE)
						latch_status(ST_TRUNCATED);
					else begin
						rem_len = 16'(rem_len - skip);
						ext_end = stop;
						phase = PH_EXT_SKIP;
					end
				end
				PH_EXT_SKIP: begin
					if (idx + 1 == ext_end)
						pick_next_phase();
				end
				PH_FRAG: begin
					if (idx == ext_end)
						nxt_proto = b;
					if (idx == ext_end + 7)
						latch_status(ST_FRAGMENT);
				end
				default: ;
				endcase
				byte_cnt = byte_cnt + 16'd1;
			end
			if (is_last) begin
				predicted_headers.push_back(summarize());
				clear();
			end
		endfunction

		task flag_mismatch(string what, logic [63:0] got, logic [63:0] want);
			if (mismatches < 40)
				$display("result %0d: %s got %0h expected %0h", results_seen, what, got, want);
			mismatches++;
		endtask

		// compare one result transfer with the oldest prediction
		task check_result(hdr_result_t got);
			hdr_result_t want;
			results_seen++;
			if (predicted_headers.size() == 0) begin
				flag_mismatch("unexpected result, status", 64'(got.status), 64'(0));
				return;
			end
			want = predicted_headers.pop_front();
			if (got.status !== want.status)
				flag_mismatch("status", 64'(got.status), 64'(want.status));
			if (got.ip_ver !== want.ip_ver)
				flag_mismatch("ip_version", 64'(got.ip_ver), 64'(want.ip_ver));
			if (got.protocol !== want.protocol)
				flag_mismatch("protocol", 64'(got.protocol), 64'(want.protocol));
			if (got.ttl !== want.ttl)
				flag_mismatch("ttl_value", 64'(got.ttl), 64'(want.ttl));
			if (got.src_hi !== want.src_hi)
				flag_mismatch("source_high", got.src_hi, want.src_hi);
			if (got.src_lo !== want.src_lo)
				flag_mismatch("source_low", got.src_lo, want.src_lo);
			if (got.dst_hi !== want.dst_hi)
				flag_mismatch("dest_high", got.dst_hi, want.dst_hi);
			if (got.dst_lo !== want.dst_lo)
				flag_mismatch("dest_low", got.dst_lo, want.dst_lo);
			if (got.plen !== want.plen)
				flag_mismatch("payload_length", 64'(got.plen), 64'(want.plen));
			if (got.flow !== want.flow)
				flag_mismatch("flow_bytes", 64'(got.flow), 64'(want.flow));
			if (got.df !== want.df)
				flag_mismatch("dont_fragment", 64'(got.df), 64'(want.df));
			if (got.frag !== want.frag)
				flag_mismatch("is_fragment", 64'(got.frag), 64'(want.frag));
		endtask

		task check_leftover();
			if (predicted_headers.size() != 0)
				flag_mismatch("packets still waiting for a result", 64'(predicted_headers.size()),
						64'(0));
		endtask
	endclass

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [7:0]  packet_byte;
	logic        last_byte;
	logic        out_valid;
	logic        out_ready;
	logic [2:0]  status;
	logic [3:0]  ip_version;
	logic [7:0]  protocol;
	logic [7:0]  ttl_value;
	logic [63:0] source_high;
	logic [63:0] source_low;
	logic [63:0] dest_high;
	logic [63:0] dest_low;
	logic [15:0] payload_length;
	logic [16:0] flow_bytes;
	logic        dont_fragment;
	logic        is_fragment;

	header_tracker tracker;
	logic [7:0]    pkt[$];
	int unsigned   bytes_driven;
	int unsigned   send_gap_pct;
	int unsigned   recv_gap_pct;
	logic          calm;

	ip_header_parser dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.packet_byte    (packet_byte),
		.last_byte      (last_byte),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.status         (status),
		.ip_version     (ip_version),
		.protocol       (protocol),
		.ttl_value      (ttl_value),
		.source_high    (source_high),
		.source_low     (source_low),
		.dest_high      (dest_high),
		.dest_low       (dest_low),
		.payload_length (payload_length),
		.flow_bytes     (flow_bytes),
		.dont_fragment  (dont_fragment),
		.is_fragment    (is_fragment)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// packet builders
	function automatic void add_fill(int unsigned n);
		repeat (n) pkt.push_back(8'($urandom));
	endfunction

	function automatic void add_v4(logic [7:0] ver_ihl, logic [15:0] total, logic [15:0] frag,
			logic [7:0] ttl, logic [7:0] proto, logic [31:0] src, logic [31:0] dst);
		pkt.push_back(ver_ihl);
		add_fill(1);
		pkt.push_back(total[15:8]);
		pkt.push_back(total[7:0]);
		add_fill(2);
		pkt.push_back(frag[15:8]);
		pkt.push_back(frag[7:0]);
		pkt.push_back(ttl);
		pkt.push_back(proto);
		add_fill(2);
		for (int i = 3; i >= 0; i--)
			pkt.push_back(src[8*i +: 8]);
		for (int i = 3; i >= 0; i--)
			pkt.push_back(dst[8*i +: 8]);
	endfunction

	function automatic void add_v6(logic [15:0] plen, logic [7:0] nh, logic [7:0] hop_limit,
			logic [63:0] s_hi, logic [63:0] s_lo, logic [63:0] d_hi, logic [63:0] d_lo);
		pkt.push_back({VER_IPV6, 4'($urandom)});
		add_fill(3);
		pkt.push_back(plen[15:8]);
		pkt.push_back(plen[7:0]);
		pkt.push_back(nh);
		pkt.push_back(hop_limit);
		for (int i = 7; i >= 0; i--)
			pkt.push_back(s_hi[8*i +: 8]);
		for (int i = 7; i >= 0; i--)
			pkt.push_back(s_lo[8*i +: 8]);
		for (int i = 7; i >= 0; i--)
			pkt.push_back(d_hi[8*i +: 8]);
		for (int i = 7; i >= 0; i--)
			pkt.push_back(d_lo[8*i +: 8]);
	endfunction

	// extension header of (len + 1) * 8 bytes
	function automatic void add_ext(logic [7:0] nh, logic [7:0] len);
		pkt.push_back(nh);
		pkt.push_back(len);
		add_fill((len + 32'd1) * 8 - 2);
	endfunction

	function automatic void add_frag(logic [7:0] nh);
		pkt.push_back(nh);
		add_fill(7);
	endfunction

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic logic [7:0] pick_ext_code();
		case ($urandom_range(0, 3))
		0: return NH_HOP_BY_HOP;
		1: return NH_ROUTING;
		2: return NH_DEST_OPTS;
		default: return NH_AUTH;
		endcase
	endfunction

	function automatic logic [7:0] pick_transport();
		case ($urandom_range(0, 3))
		0: return PROTO_TCP;
		1: return PROTO_UDP;
		2: return PROTO_ICMPV6;
		default: return 8'($urandom);
		endcase
	endfunction

	function automatic int unsigned pick_gap_rate();
		case ($urandom_range(0, 2))
		0: return 0;
		1: return 6;
		default: return 30;
		endcase
	endfunction

	// one byte transfer, with an optional idle burst before it
	task automatic send_byte(logic [7:0] b, logic is_last);
		if (!calm && send_gap_pct != 0 && $urandom_range(0, 99) < send_gap_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(negedge clk);
		end
		in_valid <= 1'b1;
		packet_byte <= b;
		last_byte <= is_last;
		do @(posedge clk); while (!in_ready);
		tracker.parse_byte(b, is_last);
		bytes_driven++;
		@(negedge clk);
	endtask

	task automatic send_packet();
		for (int i = 0; i < pkt.size(); i++)
			send_byte(pkt[i], i == pkt.size() - 1);
		pkt.delete();
	endtask

	// drop a random number of trailing bytes, keeping at least one
	function automatic void chop_tail();
		repeat ($urandom_range(1, pkt.size() - 1)) void'(pkt.pop_back());
	endfunction

	task automatic make_random_v4();
		int unsigned ihl;
		int unsigned tail;
		int unsigned total;
		logic [15:0] frag;
		ihl = ($urandom_range(0, 4) != 0) ? 5 : $urandom_range(0, 15);
		tail = $urandom_range(0, 40);
		case ($urandom_range(0, 7))
		0: frag = FLAG_MF | 16'($urandom_range(0, OFFSET_MASK));
		1: frag = 16'($urandom_range(1, OFFSET_MASK));
		2: frag = 16'($urandom);
		3, 4: frag = FLAG_DF;
		default: frag = 16'h0;
		endcase
		total = ihl * 4 + tail;
		if ($urandom_range(0, 9) == 0)
			total = $urandom_range(0, 65535);
		add_v4({VER_IPV4, 4'(ihl)}, 16'(total), frag, 8'($urandom), pick_transport(),
				$urandom, $urandom);
		add_fill(((ihl > 5) ? ihl * 4 - 20 : 0) + tail +
				(($urandom_range(0, 5) == 0) ? $urandom_range(1, 4) : 0));
	endtask

	// ipv6 with a chain of extension headers and maybe a fragment header
	task automatic make_random_v6();
		logic [7:0]  chain[$];
		int unsigned lens[$];
		int unsigned n_ext;
		int unsigned tail;
		int unsigned plen;
		logic        has_frag;
		n_ext = $urandom_range(0, 3);
		has_frag = ($urandom_range(0, 3) == 0);
		tail = $urandom_range(0, 40);
		plen = tail;
		for (int i = 0; i < n_ext; i++) begin
			chain.push_back(pick_ext_code());
			lens.push_back(($urandom_range(0, 39) == 0) ? $urandom_range(0, 255)
					: $urandom_range(0, 3));
			plen += (lens[i] + 1) * 8;
		end
		if (has_frag) begin
			chain.push_back(NH_FRAGMENT);
			plen += 8;
		end
		chain.push_back(pick_transport());
		if ($urandom_range(0, 7) == 0)
			plen = $urandom_range(0, 200);
		add_v6(16'(plen), chain[0], 8'($urandom), rand64(), rand64(), rand64(), rand64());
		for (int i = 0; i < n_ext; i++)
			add_ext(chain[i + 1], 8'(lens[i]));
		if (has_frag)
			add_frag(chain[n_ext + 1]);
		add_fill(tail + (($urandom_range(0, 5) == 0) ? $urandom_range(1, 4) : 0));
	endtask

	task automatic make_noise();
		add_fill($urandom_range(1, 60));
		case ($urandom_range(0, 3))
		0: pkt[0] = {VER_IPV4, pkt[0][3:0]};
		1: pkt[0] = {VER_IPV6, pkt[0][3:0]};
		default: ;
		endcase
	endtask

	// extremes, every status and every header kind
	task automatic run_directed();
		// smallest clean ipv4
		add_v4({VER_IPV4, 4'd5}, 16'd20, 16'h0, 8'd64, PROTO_TCP, 32'h0a000001, 32'h0a000002);
		send_packet();
		// largest header, all ones, DF set
		add_v4({VER_IPV4, 4'd15}, 16'd68, FLAG_DF, 8'hff, 8'hff, 32'hffffffff, 32'hffffffff);
		add_fill(48);
		send_packet();
		// header length zero and four are malformed
		add_v4({VER_IPV4, 4'd0}, 16'h0, 16'h0, 8'h0, 8'h0, 32'h0, 32'h0);
		send_packet();
		add_v4({VER_IPV4, 4'd4}, 16'd20, 16'h0, 8'd1, PROTO_UDP, $urandom, $urandom);
		send_packet();
		// ipv4 shorter than the fixed header
		add_v4({VER_IPV4, 4'd5}, 16'd20, 16'h0, 8'd9, PROTO_UDP, $urandom, $urandom);
		void'(pkt.pop_back());
		send_packet();
		pkt.push_back({VER_IPV4, 4'd5});
		send_packet();
		// capture shorter than the header length
		add_v4({VER_IPV4, 4'd6}, 16'd24, 16'h0, 8'd9, PROTO_UDP, $urandom, $urandom);
		send_packet();
		// more fragments, largest offset, reserved bit alone is no fragment
		add_v4({VER_IPV4, 4'd5}, 16'd20, FLAG_MF, 8'd3, PROTO_TCP, $urandom, $urandom);
		send_packet();
		add_v4({VER_IPV4, 4'd5}, 16'd28, OFFSET_MASK, 8'd3, PROTO_TCP, $urandom, $urandom);
		add_fill(8);
		send_packet();
		add_v4({VER_IPV4, 4'd5}, 16'd20, FLAG_RSVD, 8'd3, PROTO_TCP, $urandom, $urandom);
		send_packet();
		// total length below the header and beyond the capture
		add_v4({VER_IPV4, 4'd5}, 16'd19, 16'h0, 8'd7, PROTO_UDP, $urandom, $urandom);
		send_packet();
		add_v4({VER_IPV4, 4'd5}, 16'hffff, 16'h0, 8'd7, PROTO_UDP, $urandom, $urandom);
		add_fill(3);
		send_packet();
		// unknown versions
		pkt.push_back(8'h00);
		send_packet();
		pkt.push_back(8'hff);
		add_fill(30);
		send_packet();
		// smallest clean ipv6, then all ones
		add_v6(16'd0, PROTO_TCP, 8'd0, 64'h0, 64'h0, 64'h0, 64'h0);
		send_packet();
		add_v6(16'd0, 8'hff, 8'hff, '1, '1, '1, '1);
		send_packet();
		// every extension header kind in one chain
		add_v6(16'd74, NH_HOP_BY_HOP, 8'd64, rand64(), rand64(), rand64(), rand64());
		add_ext(NH_ROUTING, 8'd0);
		add_ext(NH_DEST_OPTS, 8'd1);
		add_ext(NH_AUTH, 8'd0);
		add_ext(PROTO_TCP, 8'd2);
		add_fill(10);
		send_packet();
		// extension header longer than the payload
		add_v6(16'd8, NH_ROUTING, 8'd64, rand64(), rand64(), rand64(), rand64());
		add_ext(PROTO_UDP, 8'd1);
		send_packet();
		// extension header cut by the end of capture
		add_v6(16'd100, NH_DEST_OPTS, 8'd64, rand64(), rand64(), rand64(), rand64());
		add_ext(PROTO_UDP, 8'd3);
		repeat (22) void'(pkt.pop_back());
		send_packet();
		// complete fragment header, then one cut short
		add_v6(16'd28, NH_FRAGMENT, 8'd5, rand64(), rand64(), rand64(), rand64());
		add_frag(PROTO_UDP);
		add_fill(20);
		send_packet();
		add_v6(16'd28, NH_FRAGMENT, 8'd5, rand64(), rand64(), rand64(), rand64());
		add_fill(5);
		send_packet();
		// payload beyond the capture, header cut short
		add_v6(16'd50, PROTO_TCP, 8'd5, rand64(), rand64(), rand64(), rand64());
		add_fill(10);
		send_packet();
		add_v6(16'd0, PROTO_TCP, 8'd5, rand64(), rand64(), rand64(), rand64());
		void'(pkt.pop_back());
		send_packet();
		// chain cut before the next-header byte and before the length byte
		add_v6(16'd16, NH_HOP_BY_HOP, 8'd5, rand64(), rand64(), rand64(), rand64());
		send_packet();
		add_v6(16'd16, NH_AUTH, 8'd5, rand64(), rand64(), rand64(), rand64());
		pkt.push_back(PROTO_TCP);
		send_packet();
	endtask

	// result side: ready with random stall bursts
	initial begin
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!calm && recv_gap_pct != 0 && $urandom_range(0, 99) < recv_gap_pct) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 11)) @(negedge clk);
			end
			out_ready <= 1'b1;
		end
	end

	// sample each result transfer
	always @(posedge clk) begin : grab_result
		hdr_result_t seen;
		if (arst_n && out_valid && out_ready) begin
			seen.status = status;
			seen.ip_ver = ip_version;
			seen.protocol = protocol;
			seen.ttl = ttl_value;
			seen.src_hi = source_high;
			seen.src_lo = source_low;
			seen.dst_hi = dest_high;
			seen.dst_lo = dest_low;
			seen.plen = payload_length;
			seen.flow = flow_bytes;
			seen.df = dont_fragment;
			seen.frag = is_fragment;
			tracker.check_result(seen);
		end
	end

	// stimulus and end of run
	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		packet_byte = 8'h0;
		last_byte = 1'b0;
		calm = 1'b0;
		send_gap_pct = 10;
		recv_gap_pct = 10;
		bytes_driven = 0;
		tracker = new();
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		run_directed();

		// random packets, mostly well formed, idling off near the end
		while (bytes_driven < 1900) begin
			calm = (bytes_driven >= 1600);
			send_gap_pct = pick_gap_rate();
			recv_gap_pct = pick_gap_rate();
			case ($urandom_range(0, 9))
			0, 1, 2, 3: make_random_v4();
			4, 5, 6, 7: make_random_v6();
			default: make_noise();
			endcase
			if (pkt.size() > 1 && $urandom_range(0, 7) == 0)
				chop_tail();
			send_packet();
		end
		in_valid <= 1'b0;

		// wait for outstanding results, then check that none are left
		for (int n = 0; n < 5000 && tracker.predicted_headers.size() != 0; n++)
			@(posedge clk);
		repeat (8) @(posedge clk);
		tracker.check_leftover();
		if (tracker.mismatches == 0)
			$display("ip_header_parser test passed");
		else
			$display("ip_header_parser test failed");
		$finish;
	end

	// hard stop well past the slowest correct run
	initial begin
		#(20_000_000);
		$display("ip_header_parser test failed");
		$finish;
	end

endmodule
